// ===== rtl/core/linear_array_deque_defines.svh =====
// ----------------------------------------------------------------------------
// linear_array_deque_defines.svh
// Assertion macros used by the deque checker file.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_DEFINES_SVH
`define LINEAR_ARRAY_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LAD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define LAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed: next-cycle implication");

`endif

// ===== rtl/core/lad_pkg.sv =====
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types for the linear array deque: opcodes, states, commands.
// ----------------------------------------------------------------------------
`default_nettype none

package lad_pkg;

   // operation codes carried on req_func
   typedef enum logic [1:0] {
      FUNC_PUSH_REAR  = 2'd0,
      FUNC_POP_FRONT  = 2'd1,
      FUNC_PUSH_FRONT = 2'd2,
      FUNC_POP_REAR   = 2'd3
   } func_type;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic execute;   // apply the latched operation to the store
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/lad_ctrl.sv =====
// ----------------------------------------------------------------------------
// lad_ctrl
// Sequencer: accept, execute, respond; one transaction may wait behind
// a pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module lad_ctrl
   import lad_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            pending_in  = 1'b0;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid   = 1'b1;
            req_ready   = !pending_ff;
            cmd.capture = req_valid && !pending_ff;
            if (rsp_ready) begin
               pending_in = 1'b0;
               state_in   = (pending_ff || cmd.capture) ? ST_EXEC : ST_IDLE;
            end else begin
               pending_in = pending_ff || cmd.capture;
            end
         end
         default: begin
            state_in   = ST_IDLE;
            pending_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lad_datapath.sv =====
// ----------------------------------------------------------------------------
// lad_datapath
// Slot memory, head/tail indices, empty flag and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lad_datapath
   import lad_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_push_value,
   output logic signed [31:0]      rsp_pop_value,
   output logic                    rsp_overflow,
   output logic                    rsp_underflow,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] slots_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   func_type    op_func_ff;
   logic [31:0] op_value_ff;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             empty_ff, empty_in;

   logic ovf_ff, ovf_in;
   logic udf_ff, udf_in;
   logic pop_ok_ff, pop_ok_in;
   logic is_empty_ff, is_full_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   // operation decode against current indices
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      ovf_in    = 1'b0;
      udf_in    = 1'b0;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      case (op_func_ff)
         FUNC_PUSH_REAR, FUNC_PUSH_FRONT: begin
            if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (op_func_ff == FUNC_PUSH_REAR) begin
               if (tail_ff == LAST) begin
                  ovf_in = 1'b1;
               end else begin
                  tail_in = tail_ff + 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = tail_ff + 1'b1;
               end
            end else begin
               if (head_ff != '0) begin
                  head_in = head_ff - 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = head_ff - 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR: begin
            if (empty_ff) begin
               udf_in = 1'b1;
            end else begin
               pop_ok_in = 1'b1;
               rd_en     = 1'b1;
               rd_addr   = (op_func_ff == FUNC_POP_FRONT) ? head_ff : tail_ff;
               if (head_ff >= tail_ff) begin
                  // last element leaves: park both ends at slot zero
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (op_func_ff == FUNC_POP_FRONT) begin
                  head_in = head_ff + 1'b1;
               end else begin
                  tail_in = tail_ff - 1'b1;
               end
            end
         end
         default: begin
            udf_in = 1'b0;
         end
      endcase
   end

   // slot memory: one write or one registered read per execute
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         slots_ff[wr_addr] <= DATA_WIDTH'(op_value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && rd_en) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   // latched transaction and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_func_ff  <= func_type'(req_func);
         op_value_ff <= $unsigned(req_push_value);
      end
      if (cmd.execute) begin
         ovf_ff      <= ovf_in;
         udf_ff      <= udf_in;
         pop_ok_ff   <= pop_ok_in;
         is_empty_ff <= empty_in;
         is_full_ff  <= !empty_in && (tail_in == LAST);
      end
   end

   // store control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   assign rsp_pop_value = pop_ok_ff ? $signed(32'(rd_data_ff)) : '0;
   assign rsp_overflow  = ovf_ff;
   assign rsp_underflow = udf_ff;
   assign rsp_is_empty  = is_empty_ff;
   assign rsp_is_full   = is_full_ff;

endmodule

`default_nettype wire

// ===== rtl/core/linear_array_deque.sv =====
// ----------------------------------------------------------------------------
// linear_array_deque
// Double-ended queue in a linear, non-wrapping array of DEPTH slots.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one transaction per operation. req_func selects push
//    rear, pop front, push front or pop rear; req_push_value is stored by
//    pushes and ignored by pops.
//  - rsp_* channel: exactly one transaction per request, in order, with
//    the popped value (zero on push or underflow), overflow, underflow,
//    and the empty/full status after the operation.
//  - Sequence: a taken request passes through the execute state, which
//    updates the store and the response registers; rsp_valid then rises
//    with the registered response.
//  - Overlap: the execute state ends in the slot memory's registered read.
//    One request may be taken while a response waits.
//  - Back-pressure: while rsp_ready is low the response holds; after one
//    queued request req_ready drops until the response is taken.
//  - Reset (synchronous, active high): store empty, head and tail at zero.
//    Slot contents are not cleared; no legal sequence reads an unwritten
//    slot, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_array_deque
   import lad_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_push_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pop_value,
   output logic                    rsp_overflow,
   output logic                    rsp_underflow,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   // command bundle from sequencer to datapath
   cmd_type cmd;

   // sequencer: owns both handshakes
   lad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: slot memory, indices and response registers
   lad_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_overflow   (rsp_overflow),
      .rsp_underflow  (rsp_underflow),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lad_checker.sv =====
// ----------------------------------------------------------------------------
// lad_checker
// Port-level checks on the deque response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_array_deque_defines.svh"

module lad_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_pop_value,
   input wire logic               rsp_overflow,
   input wire logic               rsp_underflow,
   input wire logic               rsp_is_empty,
   input wire logic               rsp_is_full
);

   // a stalled response stays up
   `LAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a response never flags both overflow and underflow
   `LAD_ASSERT_IMPLY(a_flags_excl, clock, reset, rsp_valid, !(rsp_overflow && rsp_underflow))

   // empty store is never reported full
   `LAD_ASSERT_IMPLY(a_empty_not_full, clock, reset, rsp_valid && rsp_is_empty, !rsp_is_full)

   // underflow leaves an empty store and returns zero
   `LAD_ASSERT_IMPLY(a_udf_zero, clock, reset, rsp_valid && rsp_underflow, rsp_is_empty && (rsp_pop_value == '0))

endmodule

bind linear_array_deque lad_checker u_lad_checker (.*);

`default_nettype wire
